// ===== rtl/core/cte_pkg.sv =====
package cte_pkg;

	localparam int STAMP_BITS = 32;
	localparam int ACC_W      = 40;
	localparam int OUT_W      = 32;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	typedef enum logic [3:0] {
		STEP_Y_HI   = 4'd0,
		STEP_Y_32   = 4'd1,
		STEP_Y_8    = 4'd2,
		STEP_Y_4    = 4'd3,
		STEP_Y_1    = 4'd4,
		STEP_LEAPS  = 4'd5,
		STEP_MONTH  = 4'd6,
		STEP_LEAPX  = 4'd7,
		STEP_MDAY   = 4'd8,
		STEP_ONE    = 4'd9,
		STEP_MUL24  = 4'd10,
		STEP_HOUR   = 4'd11,
		STEP_MUL60A = 4'd12,
		STEP_MIN    = 4'd13,
		STEP_MUL60B = 4'd14,
		STEP_SEC    = 4'd15
	} step_t;

	typedef struct packed {
		logic signed [8:0] years;
		logic signed [7:0] leap_days;
		logic        [3:0] month_idx;
		logic              leap_extra;
	} year_terms_t;

	function automatic logic [8:0] days_before_month(input logic [3:0] idx);
		logic [8:0] d;
		unique case (idx)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			default: d = 9'd334;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/core/cte_in_if.sv =====
interface cte_in_if;
	logic              valid;
	logic              ready;
	logic        [5:0] second;
	logic        [5:0] minute;
	logic        [4:0] hour;
	logic signed [9:0] day_of_month;
	logic signed [7:0] month;
	logic        [7:0] year_since_1900;

	modport source (
		output valid, second, minute, hour, day_of_month, month, year_since_1900,
		input  ready
	);
	modport sink (
		input  valid, second, minute, hour, day_of_month, month, year_since_1900,
		output ready
	);
endinterface

// ===== rtl/core/cte_out_if.sv =====
interface cte_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] epoch_seconds;
	logic               overflow;

	modport source (
		output valid, epoch_seconds, overflow,
		input  ready
	);
	modport sink (
		input  valid, epoch_seconds, overflow,
		output ready
	);
endinterface

// ===== rtl/core/calendar_to_epoch_seconds.sv =====
// channel | dir | handshake         | payload
// item    | in  | valid/ready       | second, minute, hour, day_of_month, month, year_since_1900
// result  | out | valid/ready       | epoch_seconds, overflow
//
// One item is a transfer, 16 passes through the shared adder and one write
// of the result register. The sequencer steps one adder that builds days by shift-add
// and then scales by 24, 60, 60.
// Reset clears the sequencer and the result valid; the datapath registers are not reset.
// item.ready is high only while idle; a result waiting on result.ready holds the next
// item in its last step until the result register frees.
module calendar_to_epoch_seconds (
	input logic      clk,
	input logic      arst_n,
	cte_in_if.sink   item,
	cte_out_if.source result
);

	cte_pkg::state_t      state_q;
	cte_pkg::step_t       step_q;
	cte_pkg::year_terms_t terms;
	cte_pkg::year_terms_t terms_q;

	logic signed [9:0]                 mday_q;
	logic        [4:0]                 hour_q;
	logic        [5:0]                 minute_q;
	logic        [5:0]                 second_q;
	logic signed [cte_pkg::ACC_W-1:0]  acc_q;

	logic signed [cte_pkg::ACC_W-1:0]  y_ext;
	logic        [cte_pkg::ACC_W-1:0]  opa;
	logic        [cte_pkg::ACC_W-1:0]  opb;
	logic        [cte_pkg::ACC_W-1:0]  addend;
	logic        [cte_pkg::ACC_W-1:0]  sum;
	logic                              sub;
	logic                              ovf;
	logic                              out_valid_q;
	logic signed [cte_pkg::OUT_W-1:0]  stamp_q;
	logic                              ovf_q;
	logic                              take;
	logic                              out_free;

	cte_fold u_fold (
		.month           (item.month),
		.year_since_1900 (item.year_since_1900),
		.terms           (terms)
	);

	assign item.ready = (state_q == cte_pkg::ST_IDLE);
	assign take       = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;

	assign y_ext = cte_pkg::ACC_W'(terms_q.years);

	always_comb begin
		opa = acc_q;
		opb = '0;
		sub = 1'b0;
		unique case (step_q)
			cte_pkg::STEP_Y_HI: begin
				opa = y_ext <<< 8;
				opb = y_ext <<< 6;
			end
			cte_pkg::STEP_Y_32:   opb = y_ext <<< 5;
			cte_pkg::STEP_Y_8:    opb = y_ext <<< 3;
			cte_pkg::STEP_Y_4:    opb = y_ext <<< 2;
			cte_pkg::STEP_Y_1:    opb = y_ext;
			cte_pkg::STEP_LEAPS:  opb = cte_pkg::ACC_W'(terms_q.leap_days);
			cte_pkg::STEP_MONTH:
				opb = cte_pkg::ACC_W'(cte_pkg::days_before_month(terms_q.month_idx));
			cte_pkg::STEP_LEAPX:  opb = cte_pkg::ACC_W'(terms_q.leap_extra);
			cte_pkg::STEP_MDAY:   opb = cte_pkg::ACC_W'(mday_q);
			cte_pkg::STEP_ONE: begin
				opb = cte_pkg::ACC_W'(1);
				sub = 1'b1;
			end
			cte_pkg::STEP_MUL24: begin
				opa = acc_q <<< 4;
				opb = acc_q <<< 3;
			end
			cte_pkg::STEP_HOUR:   opb = cte_pkg::ACC_W'(hour_q);
			cte_pkg::STEP_MUL60A, cte_pkg::STEP_MUL60B: begin
				opa = acc_q <<< 6;
				opb = acc_q <<< 2;
				sub = 1'b1;
			end
			cte_pkg::STEP_MIN:    opb = cte_pkg::ACC_W'(minute_q);
			cte_pkg::STEP_SEC:    opb = cte_pkg::ACC_W'(second_q);
			default:              opb = '0;
		endcase
	end

	assign addend = sub ? ~opb : opb;
	assign sum    = opa + addend + cte_pkg::ACC_W'(sub);

	// stamp fits when all bits from STAMP_BITS-1 upward match the sign
	always_comb begin
		ovf = 1'b0;
		for (int i = 0; i < cte_pkg::ACC_W; i++) begin
			if (i >= cte_pkg::STAMP_BITS - 1 && acc_q[i] != acc_q[cte_pkg::ACC_W-1]) begin
				ovf = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cte_pkg::ST_IDLE;
			step_q      <= cte_pkg::STEP_Y_HI;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				cte_pkg::ST_IDLE: begin
					if (take) begin
						state_q <= cte_pkg::ST_RUN;
						step_q  <= cte_pkg::STEP_Y_HI;
					end
				end
				cte_pkg::ST_RUN: begin
					if (step_q == cte_pkg::STEP_SEC) begin
						state_q <= cte_pkg::ST_DONE;
					end else begin
						step_q <= cte_pkg::step_t'(step_q + 4'd1);
					end
				end
				cte_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= cte_pkg::ST_IDLE;
					end
				end
				default: state_q <= cte_pkg::ST_IDLE;
			endcase
			if (state_q == cte_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			terms_q  <= terms;
			mday_q   <= item.day_of_month;
			hour_q   <= item.hour;
			minute_q <= item.minute;
			second_q <= item.second;
		end
		if (state_q == cte_pkg::ST_RUN) begin
			acc_q <= sum;
		end
		if (state_q == cte_pkg::ST_DONE && out_free) begin
			stamp_q <= ovf ? '1 : acc_q[cte_pkg::OUT_W-1:0];
			ovf_q   <= ovf;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.epoch_seconds = stamp_q;
	assign result.overflow      = ovf_q;

endmodule

// ===== rtl/core/cte_fold.sv =====
module cte_fold (
	input  logic signed [7:0]   month,
	input  logic        [7:0]   year_since_1900,
	output cte_pkg::year_terms_t terms
);

	logic        [8:0]  m;
	logic        [15:0] prod;
	logic        [4:0]  qp;
	logic        [8:0]  twelve_q;
	logic        [8:0]  rem;
	logic signed [9:0]  y10;
	logic        [11:0] n;
	logic               ge1901;
	logic               ge2101;
	logic        [10:0] ld;
	logic               leap_now;

	// month + 132 is 4..259; floor(m / 12) by reciprocal 171 / 2048
	assign m        = 9'($unsigned({month[7], month})) + 9'd132;
	assign prod     = 16'(m) * 16'd171;
	assign qp       = prod[15:11];
	assign twelve_q = 9'({qp, 3'b000}) + 9'({qp, 2'b00});
	assign rem      = m - twelve_q;

	// years since 1970 after folding in the month quotient
	assign y10 = $signed({2'b00, year_since_1900}) - 10'sd70
		+ $signed({5'b00000, qp}) - 10'sd11;

	// leaps in 1970 .. year-1, negative before 1970
	assign n      = 12'(y10) + 12'd1969;
	assign ge1901 = (y10 >= -10'sd69);
	assign ge2101 = (y10 >= 10'sd131);
	assign ld     = 11'({1'b0, n[11:2]}) - 11'd491 - 11'(ge1901) - 11'(ge2101);

	assign leap_now = (y10[1:0] == 2'b10) && (y10 != -10'sd70) && (y10 != 10'sd130);

	assign terms.years      = y10[8:0];
	assign terms.leap_days  = ld[7:0];
	assign terms.month_idx  = rem[3:0];
	assign terms.leap_extra = leap_now && (rem[3:0] >= 4'd2);

endmodule

// ===== tb/tb_calendar_to_epoch_seconds.sv =====
`timescale 1ns / 1ps

module tb_calendar_to_epoch_seconds;

	typedef struct {
		logic        [5:0] second;
		logic        [5:0] minute;
		logic        [4:0] hour;
		logic signed [9:0] day_of_month;
		logic signed [7:0] month;
		logic        [7:0] year_since_1900;
		bit                wait_idle;
	} cal_item_t;

	typedef struct {
		logic signed [31:0] epoch_seconds;
		logic               overflow;
	} stamp_t;

	typedef enum int {
		RDY_ALWAYS,
		RDY_HALF,
		RDY_RARE_STALL,
		RDY_TOGGLE
	} ready_mode_t;

	localparam int N_RANDOM   = 1750;
	localparam int LONG_HOLD  = 400;
	localparam int DRAIN_WAIT = 40;

	logic clk = 1'b0;
	logic arst_n;

	always #6 clk = ~clk;

	cte_in_if  item ();
	cte_out_if result ();

	calendar_to_epoch_seconds dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result)
	);

	cal_item_t   pending_items [$];
	stamp_t      expected_stamps [$];
	cal_item_t   offered;
	int          errors = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	int          overflow_seen = 0;
	int          pre_epoch_seen = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          hold_left = 0;
	bit          long_hold_done = 1'b0;
	ready_mode_t rdy_mode = RDY_ALWAYS;
	int          mode_left = 0;

	// Gregorian leap years in 1..y
	function automatic longint leaps_upto(longint y);
		return y / 4 - y / 100 + y / 400;
	endfunction

	function automatic stamp_t to_epoch(cal_item_t c);
		longint mon, q, r, yr, days, stamp, hi;
		bit     leap;
		int     m;
		stamp_t s;
		mon = longint'(c.month);
		q = mon / 12;
		if (mon % 12 < 0)
			q = q - 1;
		r = mon - 12 * q;
		yr = longint'(c.year_since_1900) + 1900 + q;
		leap = (yr % 4 == 0 && yr % 100 != 0) || (yr % 400 == 0);
		days = 365 * (yr - 1970) + leaps_upto(yr - 1) - leaps_upto(1969);
		for (m = 0; m < r; m++) begin
			if (m == 1)
				days += leap ? 29 : 28;
			else if (m == 3 || m == 5 || m == 8 || m == 10)
				days += 30;
			else
				days += 31;
		end
		days += longint'(c.day_of_month) - 1;
		stamp = days * 86400 + longint'(c.hour) * 3600 + longint'(c.minute) * 60
			+ longint'(c.second);
		hi = (longint'(1) << (cte_pkg::STAMP_BITS - 1)) - 1;
		s.overflow = (stamp > hi) || (stamp < -hi - 1);
		s.epoch_seconds = s.overflow ? '1 : stamp[31:0];
		return s;
	endfunction

	task automatic queue_item(int sec, int min, int hr, int mday, int mon, int yr);
		cal_item_t c;
		c.second = 6'(sec);
		c.minute = 6'(min);
		c.hour = 5'(hr);
		c.day_of_month = 10'(mday);
		c.month = 8'(mon);
		c.year_since_1900 = 8'(yr);
		c.wait_idle = 1'b0;
		pending_items.push_back(c);
	endtask

	function automatic cal_item_t random_item();
		cal_item_t c;
		int        kind;
		kind = $urandom_range(0, 9);
		c.wait_idle = 1'b0;
		c.second = 6'($urandom_range(0, 60));
		c.minute = 6'($urandom_range(0, 59));
		c.hour = 5'($urandom_range(0, 23));
		c.day_of_month = 10'($urandom_range(1, 31));
		c.month = 8'($urandom_range(0, 11));
		c.year_since_1900 = 8'($urandom_range(0, 255));
		if (kind == 6) begin
			// near the ends of the 32-bit stamp
			c.year_since_1900 = 8'($urandom_range(0, 1) ? $urandom_range(136, 139)
				: $urandom_range(0, 3));
		end else if (kind >= 7) begin
			c.second = 6'($urandom_range(0, 63));
			c.minute = 6'($urandom_range(0, 63));
			c.hour = 5'($urandom_range(0, 31));
			c.day_of_month = 10'($urandom_range(0, 1023));
			c.month = 8'($urandom_range(0, 255));
		end
		return c;
	endfunction

	// sender: bursts of transfers separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item.valid <= 1'b0;
			item.second <= '0;
			item.minute <= '0;
			item.hour <= '0;
			item.day_of_month <= '0;
			item.month <= '0;
			item.year_since_1900 <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (item.valid && item.ready) begin
				expected_stamps.push_back(to_epoch(offered));
				items_sent++;
			end
			if (!item.valid || item.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					item.valid <= 1'b0;
				end else if (pending_items.size() != 0 &&
					!(pending_items[0].wait_idle && expected_stamps.size() != 0)) begin
					offered <= pending_items[0];
					item.second <= pending_items[0].second;
					item.minute <= pending_items[0].minute;
					item.hour <= pending_items[0].hour;
					item.day_of_month <= pending_items[0].day_of_month;
					item.month <= pending_items[0].month;
					item.year_since_1900 <= pending_items[0].year_since_1900;
					item.valid <= 1'b1;
					void'(pending_items.pop_front());
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left--;
					end
				end else begin
					item.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each transfer and stalls on its own pattern
	always @(posedge clk or negedge arst_n) begin
		stamp_t want;
		if (!arst_n) begin
			result.ready <= 1'b0;
			hold_left = 0;
			mode_left = 0;
		end else begin
			if (result.valid && result.ready) begin
				results_seen++;
				if (expected_stamps.size() == 0) begin
					$error("result with nothing outstanding: epoch_seconds %0d overflow %0d",
						result.epoch_seconds, result.overflow);
					errors++;
				end else begin
					want = expected_stamps.pop_front();
					if (result.epoch_seconds !== want.epoch_seconds) begin
						$error("epoch_seconds: expected %0d, got %0d",
							want.epoch_seconds, result.epoch_seconds);
						errors++;
					end
					if (result.overflow !== want.overflow) begin
						$error("overflow: expected %0d, got %0d",
							want.overflow, result.overflow);
						errors++;
					end
					if (want.overflow)
						overflow_seen++;
					else if (want.epoch_seconds < 0)
						pre_epoch_seen++;
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				result.ready <= 1'b0;
			end else if (!long_hold_done && results_seen >= 300) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD;
				result.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rdy_mode = ready_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 96);
				end else begin
					mode_left--;
				end
				case (rdy_mode)
					RDY_ALWAYS:     result.ready <= 1'b1;
					RDY_HALF:       result.ready <= 1'($urandom_range(0, 1));
					RDY_RARE_STALL: result.ready <= ($urandom_range(0, 7) != 0);
					default:        result.ready <= ~result.ready;
				endcase
			end
		end
	end

	initial begin
		cal_item_t c;
		int        i;
		arst_n = 1'b0;

		queue_item(0, 0, 0, 1, 0, 70);
		queue_item(63, 63, 31, 1, 0, 70);
		queue_item(0, 0, 0, -512, 0, 100);
		queue_item(59, 59, 23, 511, 0, 100);
		queue_item(0, 0, 0, 0, 0, 70);
		queue_item(1, 2, 3, 15, -128, 150);
		queue_item(1, 2, 3, 15, 127, 60);
		queue_item(0, 0, 0, 1, -12, 71);
		queue_item(0, 0, 0, 1, -24, 80);
		queue_item(0, 0, 0, 1, 12, 80);
		queue_item(0, 0, 0, 31, 11, 80);
		queue_item(0, 0, 0, 1, -1, 80);
		queue_item(0, 0, 0, 1, 0, 0);
		queue_item(63, 63, 31, 511, 127, 255);
		queue_item(0, 0, 0, -512, -128, 0);
		queue_item(7, 14, 3, 19, 0, 138);
		queue_item(8, 14, 3, 19, 0, 138);
		queue_item(52, 45, 20, 13, 11, 1);
		queue_item(51, 45, 20, 13, 11, 1);
		queue_item(0, 0, 12, 29, 1, 100);
		queue_item(0, 0, 0, 1, 2, 200);
		queue_item(0, 0, 0, 1, 2, 0);
		queue_item(59, 59, 23, 31, 11, 69);
		for (i = 0; i < N_RANDOM; i++) begin
			c = random_item();
			if (i % 250 == 125)
				c.wait_idle = 1'b1;
			pending_items.push_back(c);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0 || item.valid || expected_stamps.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		$display("%0d transfers in, %0d results checked", items_sent, results_seen);
		$display("%0d overflowed, %0d before 1970", overflow_seen, pre_epoch_seen);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#6_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/cte_pkg.sv
rtl/core/cte_in_if.sv
rtl/core/cte_out_if.sv
rtl/core/cte_fold.sv
rtl/core/calendar_to_epoch_seconds.sv
tb/tb_calendar_to_epoch_seconds.sv
